@@ rtl/sbmu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package sbmu_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int ANG_FRAC     = 60;
  localparam int CORDIC_STEPS = 62;
  localparam int DIV_STEPS    = 32 + FRAC_BITS;
  localparam int UNIT_LAT     = CORDIC_STEPS + 3;

  localparam logic signed [63:0] PI_HALF =
    64'(longint'($atan(1.0) * 2.0 * (2.0 ** ANG_FRAC)));

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_DIV   = 3'd3,
    OP_MIN   = 3'd4,
    OP_MAX   = 3'd5,
    OP_REM   = 3'd6,
    OP_ATAN2 = 3'd7
  } op_t;

  typedef struct packed {
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               overflow;
  } out_item_t;

  // sign applied to a magnitude, saturated to 32 bits
  function automatic out_item_t sat_mag(input logic neg, input logic [DIV_STEPS-1:0] mag);
    out_item_t o;
    o.overflow = 1'b0;
    o.result_value = neg ? -$signed(mag[31:0]) : $signed(mag[31:0]);
    if (!neg && (mag > DIV_STEPS'(32'h7fff_ffff))) begin
      o.overflow = 1'b1;
      o.result_value = 32'sh7fff_ffff;
    end else if (neg && (mag > DIV_STEPS'(32'h8000_0000))) begin
      o.overflow = 1'b1;
      o.result_value = 32'sh8000_0000;
    end
    return o;
  endfunction

endpackage
`default_nettype wire

@@ rtl/sbmu_simple.sv @@
`timescale 1ns / 1ps
`default_nettype none
module sbmu_simple
  import sbmu_pkg::*;
(
  input  wire logic               clk,
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  input  wire op_t                op,
  output out_item_t               res
);

  localparam int PAD = UNIT_LAT - 1;

  logic signed [32:0] sum_r, diff_r;
  logic [63:0]        prod_r;
  logic signed [31:0] min_r, max_r;
  logic               neg_r;
  op_t                op_r;
  logic [31:0]        ma, mb;
  out_item_t          res_nxt;
  out_item_t          pad_r [PAD];

  assign ma = a[31] ? 32'(-a) : 32'(a);
  assign mb = b[31] ? 32'(-b) : 32'(b);

  always_ff @(posedge clk) begin
    sum_r  <= 33'(a) + 33'(b);
    diff_r <= 33'(a) - 33'(b);
    prod_r <= 64'(ma) * 64'(mb);
    min_r  <= (a < b) ? a : b;
    max_r  <= (a > b) ? a : b;
    neg_r  <= a[31] ^ b[31];
    op_r   <= op;
  end

  function automatic out_item_t sat33(input logic signed [32:0] v);
    out_item_t o;
    o.overflow = 1'b0;
    o.result_value = v[31:0];
    if (v > 33'sh0_7fff_ffff) begin
      o.overflow = 1'b1;
      o.result_value = 32'sh7fff_ffff;
    end else if (v < -33'sh0_8000_0000) begin
      o.overflow = 1'b1;
      o.result_value = 32'sh8000_0000;
    end
    return o;
  endfunction

  always_comb begin
    res_nxt = '0;
    case (op_r)
      OP_ADD:  res_nxt = sat33(sum_r);
      OP_SUB:  res_nxt = sat33(diff_r);
      OP_MUL:  res_nxt = sat_mag(neg_r, DIV_STEPS'(prod_r >> FRAC_BITS));
      OP_MIN:  res_nxt.result_value = min_r;
      OP_MAX:  res_nxt.result_value = max_r;
      default: res_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    pad_r[0] <= res_nxt;
    for (int k = 1; k < PAD; k++) begin
      pad_r[k] <= pad_r[k-1];
    end
  end

  assign res = pad_r[PAD-1];

endmodule
`default_nettype wire

@@ rtl/sbmu_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
module sbmu_div
  import sbmu_pkg::*;
(
  input  wire logic               clk,
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  input  wire op_t                op,
  output out_item_t               res
);

  localparam int PAD = UNIT_LAT - DIV_STEPS - 2;

  logic [32:0]          rem_r [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] dd_r  [DIV_STEPS+1];
  logic [32:0]          dvs_r [DIV_STEPS+1];
  logic                 neg_r [DIV_STEPS+1];
  logic                 aneg_r [DIV_STEPS+1];
  logic                 bz_r  [DIV_STEPS+1];
  logic                 rem_op_r [DIV_STEPS+1];
  logic [31:0]          ma, mb;
  out_item_t            res_nxt;
  out_item_t            pad_r [PAD+1];

  assign ma = a[31] ? 32'(-a) : 32'(a);
  assign mb = b[31] ? 32'(-b) : 32'(b);

  always_ff @(posedge clk) begin
    rem_r[0]    <= '0;
    dd_r[0]     <= (op == OP_REM) ? DIV_STEPS'(ma) : {ma[31-FRAC_BITS+FRAC_BITS:0], FRAC_BITS'(0)};
    dvs_r[0]    <= 33'(mb);
    neg_r[0]    <= a[31] ^ b[31];
    aneg_r[0]   <= a[31];
    bz_r[0]     <= (b == '0);
    rem_op_r[0] <= (op == OP_REM);
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    logic [32:0] t;
    logic        ge;
    assign t  = {rem_r[i][31:0], dd_r[i][DIV_STEPS-1]};
    assign ge = (t >= dvs_r[i]);
    always_ff @(posedge clk) begin
      rem_r[i+1]    <= ge ? (t - dvs_r[i]) : t;
      dd_r[i+1]     <= {dd_r[i][DIV_STEPS-2:0], ge};
      dvs_r[i+1]    <= dvs_r[i];
      neg_r[i+1]    <= neg_r[i];
      aneg_r[i+1]   <= aneg_r[i];
      bz_r[i+1]     <= bz_r[i];
      rem_op_r[i+1] <= rem_op_r[i];
    end
  end

  always_comb begin
    res_nxt = '0;
    if (!bz_r[DIV_STEPS]) begin
      if (rem_op_r[DIV_STEPS]) begin
        res_nxt.result_value = aneg_r[DIV_STEPS] ? -$signed(rem_r[DIV_STEPS][31:0])
                                                 : $signed(rem_r[DIV_STEPS][31:0]);
      end else begin
        res_nxt = sat_mag(neg_r[DIV_STEPS], dd_r[DIV_STEPS]);
      end
    end
  end

  always_ff @(posedge clk) begin
    pad_r[0] <= res_nxt;
    for (int k = 1; k <= PAD; k++) begin
      pad_r[k] <= pad_r[k-1];
    end
  end

  assign res = pad_r[PAD];

endmodule
`default_nettype wire

@@ rtl/sbmu_cordic.sv @@
`timescale 1ns / 1ps
`default_nettype none
module sbmu_cordic
  import sbmu_pkg::*;
(
  input  wire logic               clk,
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  output out_item_t               res
);

  localparam int RND = ANG_FRAC - FRAC_BITS;

  logic [31:0]        ma, mb, m;
  logic [4:0]         p;
  logic signed [31:0] a_r, b_r;
  logic [5:0]         s_r;
  logic               zero_r [CORDIC_STEPS+2];
  logic signed [63:0] x_r [CORDIC_STEPS+1];
  logic signed [63:0] y_r [CORDIC_STEPS+1];
  logic signed [63:0] z_r [CORDIC_STEPS+1];
  logic signed [63:0] xs, ys, w;
  out_item_t          res_r, res_nxt;

  assign ma = a[31] ? 32'(-a) : 32'(a);
  assign mb = b[31] ? 32'(-b) : 32'(b);
  assign m  = (ma > mb) ? ma : mb;

  always_comb begin
    p = '0;
    for (int k = 0; k < 32; k++) begin
      if (m[k]) p = 5'(k);
    end
  end

  always_ff @(posedge clk) begin
    a_r       <= a;
    b_r       <= b;
    s_r       <= 6'(59 - int'(p));
    zero_r[0] <= (m == '0);
  end

  assign xs = 64'(b_r) <<< s_r;
  assign ys = 64'(a_r) <<< s_r;

  always_ff @(posedge clk) begin
    zero_r[1] <= zero_r[0];
    if (xs < 0) begin
      if (ys >= 0) begin
        x_r[0] <= ys;
        y_r[0] <= -xs;
        z_r[0] <= PI_HALF;
      end else begin
        x_r[0] <= -ys;
        y_r[0] <= xs;
        z_r[0] <= -PI_HALF;
      end
    end else begin
      x_r[0] <= xs;
      y_r[0] <= ys;
      z_r[0] <= '0;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    localparam logic signed [63:0] ANG =
      64'(longint'($atan(2.0 ** (-i)) * (2.0 ** ANG_FRAC)));
    logic signed [63:0] sx, sy;
    assign sx = x_r[i] >>> i;
    assign sy = y_r[i] >>> i;
    always_ff @(posedge clk) begin
      zero_r[i+2] <= zero_r[i+1];
      if (y_r[i] > 0) begin
        x_r[i+1] <= x_r[i] + sy;
        y_r[i+1] <= y_r[i] - sx;
        z_r[i+1] <= z_r[i] + ANG;
      end else begin
        x_r[i+1] <= x_r[i] - sy;
        y_r[i+1] <= y_r[i] + sx;
        z_r[i+1] <= z_r[i] - ANG;
      end
    end
  end

  assign w = (z_r[CORDIC_STEPS] + (64'sd1 <<< (RND - 1))) >>> RND;

  always_comb begin
    res_nxt = '0;
    if (!zero_r[CORDIC_STEPS+1]) begin
      res_nxt.result_value = w[31:0];
      if (w > 64'sh7fff_ffff) begin
        res_nxt.overflow = 1'b1;
        res_nxt.result_value = 32'sh7fff_ffff;
      end else if (w < -64'sh8000_0000) begin
        res_nxt.overflow = 1'b1;
        res_nxt.result_value = 32'sh8000_0000;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule
`default_nettype wire

@@ rtl/scalar_binary_math_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// scalar binary math unit: two signed q16.16 operands in, one q16.16 result out
// the operation (add, sub, mul, div, min, max, remainder, atan2) comes from
// the apb register at byte address 0; write it only while no item is in flight
// input: drive in_item and raise start; a transfer happens when start is high
// and busy is low. busy is always low, so one item may enter every cycle
// output: out_valid is high for one cycle with out_item; the receiver takes
// it in that cycle and cannot hold it off
// every operation passes the same depth of registers from the transfer edge to
// the edge that raises out_valid, set by the 62 cordic stages of atan2 plus
// normalize, quadrant, rounding and output registers; divide and remainder
// share a 48-stage restoring divider padded to the same depth
// throughput is one item per cycle
// reset clears the operation register to add and drops all valid bits
module scalar_binary_math_unit
  import sbmu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire in_item_t    in_item,
  output logic             out_valid,
  output out_item_t        out_item,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  op_t                cfg_op_r;
  op_t                op_r;
  logic               vld_r;
  logic signed [31:0] a_r, b_r;
  logic               vld_d_r [UNIT_LAT];
  op_t                op_d_r  [UNIT_LAT];
  out_item_t          simple_res, div_res, cordic_res, sel;
  out_item_t          out_r;
  logic               out_valid_r;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign prdata = paddr[2] ? '0 : {29'd0, cfg_op_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_op_r <= OP_ADD;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      cfg_op_r <= op_t'(pwdata[2:0]);
    end
  end

  always_ff @(posedge clk) begin
    a_r  <= in_item.operand_a;
    b_r  <= in_item.operand_b;
    op_r <= cfg_op_r;
    op_d_r[0] <= op_r;
    for (int k = 1; k < UNIT_LAT; k++) begin
      op_d_r[k] <= op_d_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < UNIT_LAT; k++) begin
        vld_d_r[k] <= 1'b0;
      end
    end else begin
      vld_r      <= start && !busy;
      vld_d_r[0] <= vld_r;
      for (int k = 1; k < UNIT_LAT; k++) begin
        vld_d_r[k] <= vld_d_r[k-1];
      end
      out_valid_r <= vld_d_r[UNIT_LAT-1];
    end
  end

  sbmu_simple u_simple (
    .clk (clk),
    .a   (a_r),
    .b   (b_r),
    .op  (op_r),
    .res (simple_res)
  );

  sbmu_div u_div (
    .clk (clk),
    .a   (a_r),
    .b   (b_r),
    .op  (op_r),
    .res (div_res)
  );

  sbmu_cordic u_cordic (
    .clk (clk),
    .a   (a_r),
    .b   (b_r),
    .res (cordic_res)
  );

  always_comb begin
    case (op_d_r[UNIT_LAT-1])
      OP_DIV, OP_REM: sel = div_res;
      OP_ATAN2:       sel = cordic_res;
      default:        sel = simple_res;
    endcase
  end

  always_ff @(posedge clk) begin
    out_r <= sel;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
`default_nettype wire

@@ verif/scalar_binary_math_unit_tb.sv @@
`timescale 1ns / 1ps
module scalar_binary_math_unit_tb;
  import sbmu_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 2 * UNIT_LAT;
  localparam int RANDOM_ITEMS   = 1850;
  localparam int PHASES         = 16;

  class math_scoreboard;
    out_item_t  pending_q[$];
    op_t        pending_op_q[$];
    longint     angle_tab[CORDIC_STEPS];
    longint     pi_fx;
    int         mismatches;
    int         results_seen;
    int         items_noted;

    function new();
      angle_tab[0] = 4 * atan_inv(5) - atan_inv(239);
      for (int i = 1; i < CORDIC_STEPS; i++) angle_tab[i] = atan_inv(64'd1 << i);
      pi_fx = 4 * angle_tab[0];
      mismatches = 0;
      results_seen = 0;
      items_noted = 0;
    endfunction

    // atan(1/n) by its power series
    function longint atan_inv(longint unsigned n);
      longint unsigned p;
      longint unsigned k;
      longint sum;
      longint term;
      p = (64'd1 << ANG_FRAC) / n;
      sum = 0;
      k = 0;
      while (p != 0) begin
        term = longint'(p / (2 * k + 1));
        sum = (k & 1) ? sum - term : sum + term;
        p = p / n / n;
        k++;
      end
      return sum;
    endfunction

    function out_item_t clamp64(longint v);
      out_item_t o;
      o.overflow = 1'b0;
      if (v > 64'sh7fff_ffff) begin
        o.overflow = 1'b1;
        o.result_value = 32'sh7fff_ffff;
      end else if (v < -64'sh8000_0000) begin
        o.overflow = 1'b1;
        o.result_value = 32'sh8000_0000;
      end else begin
        o.result_value = v[31:0];
      end
      return o;
    endfunction

    function out_item_t signed_mag(bit neg, longint unsigned mag);
      if (mag > (64'd1 << 32)) mag = 64'd1 << 32;
      return clamp64(neg ? -longint'(mag) : longint'(mag));
    endfunction

    function longint unsigned abs64(longint v);
      return v < 0 ? longint'(-v) : v;
    endfunction

    function out_item_t cordic_atan2(longint a, longint b);
      longint unsigned m;
      longint x, y, z, t, xs, ys;
      int sh;
      out_item_t o;
      m = abs64(a) > abs64(b) ? abs64(a) : abs64(b);
      z = 0;
      sh = 0;
      o.result_value = '0;
      o.overflow = 1'b0;
      if (m == 0) return o;
      while (m < (64'd1 << 59)) begin
        m = m << 1;
        sh++;
      end
      x = b * (64'sd1 <<< sh);
      y = a * (64'sd1 <<< sh);
      if (x < 0) begin
        if (y >= 0) begin
          t = x; x = y; y = -t; z = pi_fx / 2;
        end else begin
          t = x; x = -y; y = t; z = -(pi_fx / 2);
        end
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x += ys; y -= xs; z += angle_tab[i];
        end else begin
          x -= ys; y += xs; z -= angle_tab[i];
        end
      end
      z += 64'sd1 <<< (ANG_FRAC - FRAC_BITS - 1);
      return clamp64(z >>> (ANG_FRAC - FRAC_BITS));
    endfunction

    function out_item_t compute(in_item_t it, op_t op);
      longint a, b;
      longint unsigned r;
      bit neg;
      out_item_t o;
      a = it.operand_a;
      b = it.operand_b;
      neg = (a < 0) != (b < 0);
      o.result_value = '0;
      o.overflow = 1'b0;
      case (op)
        OP_ADD: o = clamp64(a + b);
        OP_SUB: o = clamp64(a - b);
        OP_MUL: o = signed_mag(neg, (abs64(a) * abs64(b)) >> FRAC_BITS);
        OP_DIV: begin
          if (b != 0) o = signed_mag(neg, (abs64(a) << FRAC_BITS) / abs64(b));
        end
        OP_MIN: o.result_value = a < b ? a[31:0] : b[31:0];
        OP_MAX: o.result_value = a > b ? a[31:0] : b[31:0];
        OP_REM: begin
          if (b != 0) begin
            r = abs64(a) % abs64(b);
            o.result_value = a < 0 ? -longint'(r) : longint'(r);
          end
        end
        default: o = cordic_atan2(a, b);
      endcase
      return o;
    endfunction

    function void note_item(in_item_t it, op_t op);
      pending_q.push_back(compute(it, op));
      pending_op_q.push_back(op);
      items_noted++;
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      op_t op;
      bit ok;
      int diff;
      results_seen++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value %0d overflow %0d", got.result_value, got.overflow);
        return;
      end
      want = pending_q.pop_front();
      op = pending_op_q.pop_front();
      diff = int'(got.result_value) - int'(want.result_value);
      ok = (got.overflow == want.overflow) &&
           ((op == OP_ATAN2) ? (diff >= -1 && diff <= 1) : (diff == 0));
      if (!ok) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch op %s: expected value %0d overflow %0d, got value %0d overflow %0d",
                   op.name(), want.result_value, want.overflow,
                   got.result_value, got.overflow);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_item;
  logic        out_valid;
  out_item_t   out_item;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  math_scoreboard sb;
  op_t            cur_op;
  int             idle_pct;
  int             quiet_cycles;
  int             ops_used[8];

  scalar_binary_math_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_item);
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_op(input op_t op);
    write_reg(3'd0, {29'($urandom_range(0, 32'h1fff_ffff)), 3'(op)});
    cur_op = op;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_item(input in_item_t it);
    bit done;
    done = 0;
    while (!done) begin
      @(negedge clk);
      if ($urandom_range(0, 99) < idle_pct) begin
        start <= 1'b0;
        in_item <= {$urandom, $urandom};
        @(posedge clk);
      end else begin
        start <= 1'b1;
        in_item <= it;
        @(posedge clk);
        if (!busy) begin
          sb.note_item(it, cur_op);
          ops_used[cur_op]++;
          done = 1;
        end
      end
    end
  endtask

  function automatic logic [31:0] pick_operand();
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0, 1, 2: v = $urandom;
      3: v = $urandom_range(0, 32'h3_ffff) - 32'h2_0000;
      4: begin
        case ($urandom_range(0, 5))
          0: v = 32'h7fff_ffff;
          1: v = 32'h8000_0000;
          2: v = 32'hffff_ffff;
          3: v = 32'h0000_0001;
          4: v = 32'h0001_0000;
          default: v = 32'hffff_0000;
        endcase
      end
      5: v = 32'h0;
      default: v = ($urandom_range(1, 255) << FRAC_BITS) * ($urandom_range(0, 1) ? 1 : -1);
    endcase
    return v;
  endfunction

  initial begin
    in_item_t corners[$];
    in_item_t it;
    int per_phase;
    sb = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    quiet_cycles = 0;
    idle_pct = 32;
    cur_op = OP_ADD;
    foreach (ops_used[i]) ops_used[i] = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    corners.push_back('{32'sh7fff_ffff, 32'sh7fff_ffff});
    corners.push_back('{-32'sh8000_0000, -32'sh8000_0000});
    corners.push_back('{-32'sh8000_0000, -32'sh0001_0000});
    corners.push_back('{-32'sh8000_0000, 32'sh7fff_ffff});
    corners.push_back('{32'sh0003_0000, 32'sh0});
    corners.push_back('{32'sh0, 32'sh0});
    corners.push_back('{32'sh0, -32'sh0002_0000});
    corners.push_back('{-32'sh0007_8000, 32'sh0002_0000});
    corners.push_back('{32'sh0000_0001, -32'sh0000_0001});

    // reset value of the register is add
    foreach (corners[i]) send_item(corners[i]);
    for (int op = 1; op < 8; op++) begin
      wait_drained();
      set_op(op_t'(op));
      foreach (corners[i]) send_item(corners[i]);
    end
    // address past the register list is ignored
    wait_drained();
    write_reg(3'd4, 32'h0000_0003);
    foreach (corners[i]) send_item(corners[i]);

    per_phase = RANDOM_ITEMS / PHASES;
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      set_op(ph < 8 ? op_t'(ph) : op_t'($urandom_range(0, 7)));
      idle_pct = (ph == 5) ? 0 : 32;
      for (int n = 0; n < per_phase; n++) begin
        it.operand_a = pick_operand();
        it.operand_b = pick_operand();
        send_item(it);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d items over all eight operations with corner operands and zero divisors",
             sb.items_noted);
    $display("items per op: add %0d sub %0d mul %0d div %0d min %0d max %0d rem %0d atan2 %0d",
             ops_used[0], ops_used[1], ops_used[2], ops_used[3],
             ops_used[4], ops_used[5], ops_used[6], ops_used[7]);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/sbmu_pkg.sv
rtl/sbmu_simple.sv
rtl/sbmu_div.sv
rtl/sbmu_cordic.sv
rtl/scalar_binary_math_unit.sv
verif/scalar_binary_math_unit_tb.sv
